/* rtl/tdes_pkg.sv */
package tdes_pkg;

   // field widths of one item and one table entry
   localparam int TIME_W      = 17;
   localparam int CMD_W       = 9;
   localparam int TEMP_W      = 7;
   localparam int ENTRY_W     = TIME_W + CMD_W;
   localparam int LEAD_W      = 8;
   localparam int MODE_W      = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int CSR_IDX_W   = 2;

   // time constants
   localparam int SECONDS_PER_HOUR = 60 * 60;
   localparam int SECONDS_PER_DAY  = 60 * 60 * 24;

   // table size default
   localparam int TABLE_DEPTH_DEFAULT = 16;

   // register reset values
   localparam logic [LEAD_W-1:0] LEAD_RESET = LEAD_W'(30);
   localparam logic [TIME_W-1:0] IDLE_RESET = TIME_W'(SECONDS_PER_HOUR);

   // item modes
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEAD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE = 2'd1;

endpackage

/* rtl/tdes_ram.sv */
module tdes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* rtl/time_of_day_event_scheduler_unit.sv */
// Time-of-day event scheduler.
// Input channel (req_*): one item per handshake, accepted when req_valid is
// high and req_stall is low. Mode tick fires the head entry if it is due and
// rotates it to the tail, mode add inserts an entry in time-of-day order from
// now, mode clear empties the table; any other mode only reports.
// Result channel (rsp_*): exactly one result item per input item, held in an
// output register until taken (rsp_valid high, rsp_stall low).
// Config channel (csr_*): csr_ready is always high; index 0 is the fire lead
// in seconds, index 1 the wait reported for an empty table. Write only while
// no item is in flight.
// An add on a full table is dropped and sets rsp_status. Clear, report and a
// tick that is not due skip the walk over the entry table (one write port, one
// registered read port): one search read and one shift move per entry.
// req_stall is high from acceptance until the result is loaded into the
// output register; a new item may be accepted while that result still waits.
// If the receiver stalls, the next result waits in its last state until the
// output register frees up.
// Reset (synchronous): empty table, registers back to 30 s lead and 3600 s
// idle wait, no result pending. Table contents need no clearing.
module time_of_day_event_scheduler_unit
   import tdes_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // input items
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [TIME_W-1:0]      req_now_seconds,
   input  logic [TIME_W-1:0]      req_entry_time,
   input  logic                   req_entry_on,
   input  logic                   req_entry_type,
   input  logic [TEMP_W-1:0]      req_entry_temp,
   // result items
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_fired,
   output logic                   rsp_cmd_on,
   output logic                   rsp_cmd_type,
   output logic [TEMP_W-1:0]      rsp_cmd_temp,
   output logic [TIME_W-1:0]      rsp_wait_seconds,
   output logic                   rsp_status,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [TIME_W-1:0]      csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      IDLE,
      TICK_RD,
      TICK_CHK,
      SCAN,
      MOVE,
      MOVE_END,
      PUT,
      HEAD_RD,
      HEAD_USE
   } state_type;

   state_type           state_ff;
   logic [LEAD_W-1:0]   lead_ff;
   logic [TIME_W-1:0]   idle_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [ENTRY_W-1:0]  put_data_ff;
   logic [IDX_W-1:0]    put_addr_ff;
   logic [IDX_W-1:0]    cur_ff;
   logic [IDX_W-1:0]    end_ff;
   logic [IDX_W-1:0]    chk_ff;
   logic [IDX_W-1:0]    dst_ff;
   logic                dir_up_ff;
   logic                pend_ff;
   logic                vld_ff;
   logic                fwd_ff;
   logic                fired_ff;
   logic [CMD_W-1:0]    fcmd_ff;
   logic                status_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_fired_ff;
   logic                   rsp_cmd_on_ff;
   logic                   rsp_cmd_type_ff;
   logic [TEMP_W-1:0]      rsp_cmd_temp_ff;
   logic [TIME_W-1:0]      rsp_wait_ff;
   logic                   rsp_status_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;

   // table port
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [ENTRY_W-1:0]  rd_data;

   logic [TIME_W-1:0]   rd_time;
   logic [TIME_W-1:0]   new_time;
   logic [IDX_W-1:0]    last_idx;
   logic                count_full;
   logic [TIME_W:0]     fire_lim;
   logic                fire_hit;
   logic                scan_hit;
   logic [IDX_W-1:0]    scan_pos;
   logic [TIME_W:0]     wait_sum;
   logic [TIME_W-1:0]   head_wait;
   logic                rsp_free;
   logic [31:0]         count_wide;

   tdes_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cur_ff),
      .rd_data (rd_data)
   );

   // handshake outputs
   assign req_stall = (state_ff != IDLE);
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // entry fields and table bounds
   assign rd_time    = rd_data[ENTRY_W-1 -: TIME_W];
   assign new_time   = put_data_ff[ENTRY_W-1 -: TIME_W];
   assign last_idx   = IDX_W'(count_ff - CNT_W'(1));
   assign count_full = (count_ff >= CNT_W'(TABLE_DEPTH));

   // fire test, no wrap on the sum
   assign fire_lim = {1'b0, now_ff} + (TIME_W + 1)'(lead_ff);
   assign fire_hit = ({1'b0, rd_time} < fire_lim);

   // insert search: forward stops at a later or past entry,
   // backward stops at an earlier or still-ahead entry
   always_comb begin
      if (fwd_ff) begin
         scan_hit = (rd_time > new_time) || (rd_time < now_ff);
         scan_pos = scan_hit ? chk_ff : chk_ff + IDX_W'(1);
      end else begin
         scan_hit = (rd_time < new_time) || (rd_time > now_ff);
         scan_pos = scan_hit ? chk_ff + IDX_W'(1) : '0;
      end
   end

   // wait until head, wrapped at midnight
   always_comb begin
      if (rd_time >= now_ff) begin
         wait_sum = {1'b0, rd_time} - {1'b0, now_ff};
      end else begin
         wait_sum = {1'b0, rd_time} + (TIME_W + 1)'(SECONDS_PER_DAY) - {1'b0, now_ff};
      end
      head_wait = (count_ff == '0) ? idle_ff : wait_sum[TIME_W-1:0];
   end

   assign count_wide = 32'(count_ff);

   // table writes: shift moves and the final put
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = dst_ff;
      wr_data = rd_data;
      unique case (state_ff)
         MOVE: begin
            wr_en = pend_ff;
         end
         MOVE_END: begin
            wr_en = 1'b1;
         end
         PUT: begin
            wr_en   = 1'b1;
            wr_addr = put_addr_ff;
            wr_data = put_data_ff;
         end
         default: begin
         end
      endcase
   end

   // sequencer, registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         lead_ff      <= LEAD_RESET;
         idle_ff      <= IDLE_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         vld_ff       <= 1'b0;
      end else begin
         // configuration writes
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LEAD: lead_ff <= csr_wdata[LEAD_W-1:0];
               CSR_IDLE: idle_ff <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  mode_ff     <= req_mode;
                  now_ff      <= req_now_seconds;
                  put_data_ff <= {req_entry_time, req_entry_on, req_entry_type,
                                  req_entry_temp};
                  fired_ff    <= 1'b0;
                  fcmd_ff     <= '0;
                  status_ff   <= 1'b0;
                  cur_ff      <= '0;
                  vld_ff      <= 1'b0;
                  unique case (req_mode)
                     MODE_TICK: begin
                        state_ff <= (count_ff == '0) ? HEAD_RD : TICK_RD;
                     end
                     MODE_ADD: begin
                        if (count_full) begin
                           status_ff <= 1'b1;
                           state_ff  <= HEAD_RD;
                        end else if (count_ff == '0) begin
                           put_addr_ff <= '0;
                           state_ff    <= PUT;
                        end else if (req_entry_time > req_now_seconds) begin
                           fwd_ff   <= 1'b1;
                           end_ff   <= last_idx;
                           state_ff <= SCAN;
                        end else begin
                           fwd_ff   <= 1'b0;
                           cur_ff   <= last_idx;
                           end_ff   <= '0;
                           state_ff <= SCAN;
                        end
                     end
                     MODE_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= HEAD_RD;
                     end
                     default: begin
                        state_ff <= HEAD_RD;
                     end
                  endcase
               end
            end

            TICK_RD: begin
               state_ff <= TICK_CHK;
            end

            // head entry due: rotate it to the tail
            TICK_CHK: begin
               if (fire_hit) begin
                  fired_ff    <= 1'b1;
                  fcmd_ff     <= rd_data[CMD_W-1:0];
                  put_data_ff <= rd_data;
                  put_addr_ff <= last_idx;
                  if (count_ff > CNT_W'(1)) begin
                     cur_ff    <= IDX_W'(1);
                     end_ff    <= last_idx;
                     dir_up_ff <= 1'b1;
                     pend_ff   <= 1'b0;
                     state_ff  <= MOVE;
                  end else begin
                     state_ff <= PUT;
                  end
               end else begin
                  state_ff <= HEAD_RD;
               end
            end

            // pipelined search, one entry read per cycle
            SCAN: begin
               chk_ff <= cur_ff;
               vld_ff <= 1'b1;
               if (cur_ff != end_ff) begin
                  cur_ff <= fwd_ff ? cur_ff + IDX_W'(1) : cur_ff - IDX_W'(1);
               end
               if (vld_ff && (scan_hit || (chk_ff == end_ff))) begin
                  vld_ff      <= 1'b0;
                  put_addr_ff <= scan_pos;
                  if (CNT_W'(scan_pos) == count_ff) begin
                     state_ff <= PUT;
                  end else begin
                     cur_ff    <= last_idx;
                     end_ff    <= scan_pos;
                     dir_up_ff <= 1'b0;
                     pend_ff   <= 1'b0;
                     state_ff  <= MOVE;
                  end
               end
            end

            // shift entries by one place, read and write overlapped
            MOVE: begin
               dst_ff  <= dir_up_ff ? cur_ff - IDX_W'(1) : cur_ff + IDX_W'(1);
               pend_ff <= 1'b1;
               if (cur_ff == end_ff) begin
                  state_ff <= MOVE_END;
               end else begin
                  cur_ff <= dir_up_ff ? cur_ff + IDX_W'(1) : cur_ff - IDX_W'(1);
               end
            end

            MOVE_END: begin
               pend_ff  <= 1'b0;
               state_ff <= PUT;
            end

            PUT: begin
               if (mode_ff == MODE_ADD) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
               cur_ff   <= '0;
               state_ff <= HEAD_RD;
            end

            HEAD_RD: begin
               state_ff <= HEAD_USE;
            end

            // load the result once the output register is free
            HEAD_USE: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_fired_ff    <= fired_ff;
                  rsp_cmd_on_ff   <= fcmd_ff[CMD_W-1];
                  rsp_cmd_type_ff <= fcmd_ff[CMD_W-2];
                  rsp_cmd_temp_ff <= fcmd_ff[TEMP_W-1:0];
                  rsp_wait_ff     <= head_wait;
                  rsp_status_ff   <= status_ff;
                  rsp_count_ff    <= count_wide[COUNT_OUT_W-1:0];
                  state_ff        <= IDLE;
               end
            end

            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_cmd_on       = rsp_cmd_on_ff;
   assign rsp_cmd_type     = rsp_cmd_type_ff;
   assign rsp_cmd_temp     = rsp_cmd_temp_ff;
   assign rsp_wait_seconds = rsp_wait_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;

   // the table never holds more entries than it has
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // the count only grows by one or drops to empty
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ((count_ff == $past(count_ff) + CNT_W'(1)) || (count_ff == '0)))
      else $error("entry count changed by an illegal step");

   // a new result only comes from the final sequencer state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == HEAD_USE))
      else $error("result loaded outside the report state");

   // a fired tick never reports a dropped add
   a_fire_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_fired_ff && rsp_status_ff))
      else $error("fired and dropped flags both set");

endmodule

/* dv/tb_time_of_day_event_scheduler_unit.sv */
`timescale 1ns / 100ps

import tdes_pkg::*;

localparam int DEPTH = TABLE_DEPTH_DEFAULT;
// mode 3 has no action of its own, the block only reports
localparam logic [MODE_W-1:0] MODE_REPORT = 2'd3;

// one input item
typedef struct packed {
   logic [MODE_W-1:0] mode;
   logic [TIME_W-1:0] now_s;
   logic [TIME_W-1:0] at_time;
   logic              on;
   logic              heat;
   logic [TEMP_W-1:0] temp;
} sched_item_type;

// one result item
typedef struct packed {
   logic                   fired;
   logic                   on;
   logic                   heat;
   logic [TEMP_W-1:0]      temp;
   logic [TIME_W-1:0]      wait_s;
   logic                   dropped;
   logic [COUNT_OUT_W-1:0] count;
} sched_report_type;

// shadow of the schedule table plus the queue of reports it predicts
class schedule_scoreboard;
   logic [TIME_W-1:0] entry_at [DEPTH];
   logic [CMD_W-1:0]  cmd_at [DEPTH];
   int                entries_held;
   logic [LEAD_W-1:0] lead_s;
   logic [TIME_W-1:0] idle_s;
   sched_report_type  due_reports [$];
   int                errors;
   int                checked;
   int                fired_count;
   int                drop_count;

   function new();
      entries_held = 0;
      lead_s = LEAD_RESET;
      idle_s = IDLE_RESET;
      errors = 0;
      checked = 0;
      fired_count = 0;
      drop_count = 0;
   endfunction

   function void set_register(logic [CSR_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
      if (idx == CSR_LEAD) lead_s = value[LEAD_W-1:0];
      else if (idx == CSR_IDLE) idle_s = value;
   endfunction

   function int pending();
      return due_reports.size();
   endfunction

   // insertion point in time-of-day order starting from now
   function int slot_for(int now_s, int t);
      int pos;
      int i;
      if (t > now_s) begin
         pos = entries_held;
         for (i = 0; i < entries_held; i++) begin
            if (int'(entry_at[i]) > t || int'(entry_at[i]) < now_s) begin
               pos = i;
               break;
            end
         end
      end else begin
         pos = 0;
         for (i = entries_held; i > 0; i--) begin
            if (int'(entry_at[i-1]) < t || int'(entry_at[i-1]) > now_s) begin
               pos = i;
               break;
            end
         end
      end
      return pos;
   endfunction

   // apply one accepted item to the shadow table and queue its report
   function void note_item(sched_item_type it);
      sched_report_type want;
      logic [TIME_W-1:0] head_t;
      logic [CMD_W-1:0] head_c;
      int pos;
      int i;
      int d;
      want = '0;
      case (it.mode)
         MODE_TICK: begin
            if (entries_held > 0 && int'(entry_at[0]) < int'(it.now_s) + int'(lead_s)) begin
               head_t = entry_at[0];
               head_c = cmd_at[0];
               want.fired = 1'b1;
               want.on = head_c[8];
               want.heat = head_c[7];
               want.temp = head_c[TEMP_W-1:0];
               for (i = 1; i < entries_held; i++) begin
                  entry_at[i-1] = entry_at[i];
                  cmd_at[i-1] = cmd_at[i];
               end
               entry_at[entries_held-1] = head_t;
               cmd_at[entries_held-1] = head_c;
            end
         end
         MODE_ADD: begin
            if (entries_held >= DEPTH) begin
               want.dropped = 1'b1;
            end else begin
               pos = slot_for(int'(it.now_s), int'(it.at_time));
               for (i = entries_held; i > pos; i--) begin
                  entry_at[i] = entry_at[i-1];
                  cmd_at[i] = cmd_at[i-1];
               end
               entry_at[pos] = it.at_time;
               cmd_at[pos] = {it.on, it.heat, it.temp};
               entries_held++;
            end
         end
         MODE_CLEAR: entries_held = 0;
         default: ;
      endcase
      // wait until the head entry, wrapped at midnight
      if (entries_held == 0) begin
         want.wait_s = idle_s;
      end else begin
         d = int'(entry_at[0]) - int'(it.now_s);
         if (d < 0) d += SECONDS_PER_DAY;
         want.wait_s = d[TIME_W-1:0];
      end
      want.count = entries_held[COUNT_OUT_W-1:0];
      due_reports.insert(due_reports.size(), want);
   endfunction

   task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task compare_field(string name, int got, int want);
      if (got != want)
         report($sformatf("result %0d %s got %0d expected %0d", checked, name, got, want));
   endtask

   // compare one taken result with the oldest pending report
   task check_report(sched_report_type got);
      sched_report_type want;
      if (due_reports.size() == 0) begin
         report($sformatf("result %0d arrived with no item pending", checked));
         checked++;
         return;
      end
      want = due_reports.pop_front();
      compare_field("fired", got.fired, want.fired);
      compare_field("cmd_on", got.on, want.on);
      compare_field("cmd_type", got.heat, want.heat);
      compare_field("cmd_temp", got.temp, want.temp);
      compare_field("wait_seconds", got.wait_s, want.wait_s);
      compare_field("status", got.dropped, want.dropped);
      compare_field("entry_count", got.count, want.count);
      if (want.fired) fired_count++;
      if (want.dropped) drop_count++;
      checked++;
   endtask
endclass

module tb_time_of_day_event_scheduler_unit;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 2 * DEPTH + 10;
   localparam int HOLD_CYCLES = 300;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [MODE_W-1:0]      req_mode = MODE_TICK;
   logic [TIME_W-1:0]      req_now_seconds = '0;
   logic [TIME_W-1:0]      req_entry_time = '0;
   logic                   req_entry_on = 1'b0;
   logic                   req_entry_type = 1'b0;
   logic [TEMP_W-1:0]      req_entry_temp = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_fired;
   logic                   rsp_cmd_on;
   logic                   rsp_cmd_type;
   logic [TEMP_W-1:0]      rsp_cmd_temp;
   logic [TIME_W-1:0]      rsp_wait_seconds;
   logic                   rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_LEAD;
   logic [TIME_W-1:0]      csr_wdata = '0;

   schedule_scoreboard sb = new();

   int items_sent = 0;
   int burst_left = 1;
   int max_gap = 6;
   int clock_now = 0;
   int quiet_cycles = 0;
   int cycle_count = 0;
   int results_taken = 0;
   int hold_left = 0;
   int stall_style = 0;

   time_of_day_event_scheduler_unit #(
      .TABLE_DEPTH(DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_now_seconds(req_now_seconds),
      .req_entry_time(req_entry_time),
      .req_entry_on(req_entry_on),
      .req_entry_type(req_entry_type),
      .req_entry_temp(req_entry_temp),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_fired(rsp_fired),
      .rsp_cmd_on(rsp_cmd_on),
      .rsp_cmd_type(rsp_cmd_type),
      .rsp_cmd_temp(rsp_cmd_temp),
      .rsp_wait_seconds(rsp_wait_seconds),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // offer one item and hold it until taken, then maybe pause between bursts
   task automatic send_item(input sched_item_type it);
      int gap;
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_now_seconds <= it.now_s;
      req_entry_time <= it.at_time;
      req_entry_on <= it.on;
      req_entry_type <= it.heat;
      req_entry_temp <= it.temp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(it);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, max_gap);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic offer(input logic [MODE_W-1:0] mode, input int now_s, input int at_time,
                        input int on, input int heat, input int temp);
      sched_item_type it;
      it.mode = mode;
      it.now_s = now_s[TIME_W-1:0];
      it.at_time = at_time[TIME_W-1:0];
      it.on = on[0];
      it.heat = heat[0];
      it.temp = temp[TEMP_W-1:0];
      send_item(it);
   endtask

   // a time of day, weighted toward the edges and around bit 16
   function automatic int pick_time();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 0;
         1: return SECONDS_PER_DAY - 1;
         2: return $urandom_range(65530, 65541);
         default: return $urandom_range(0, SECONDS_PER_DAY - 1);
      endcase
   endfunction

   // random item: mostly adds and ticks so the table fills and rotates
   function automatic sched_item_type random_item(input int clear_pct);
      sched_item_type it;
      int r;
      int now_s;
      int t;
      r = $urandom_range(0, 99);
      if (r < clear_pct) it.mode = MODE_CLEAR;
      else if (r < clear_pct + 4) it.mode = MODE_REPORT;
      else if (r < clear_pct + 52) it.mode = MODE_ADD;
      else it.mode = MODE_TICK;
      // now either follows a running clock or jumps
      if ($urandom_range(0, 99) < 45) begin
         clock_now = (clock_now + $urandom_range(0, 900)) % SECONDS_PER_DAY;
         now_s = clock_now;
      end else begin
         now_s = pick_time();
      end
      r = $urandom_range(0, 9);
      if (r < 3)
         t = (now_s + $urandom_range(0, 1200) - 600 + SECONDS_PER_DAY) % SECONDS_PER_DAY;
      else if (r == 3)
         t = now_s;
      else
         t = pick_time();
      it.now_s = now_s[TIME_W-1:0];
      it.at_time = t[TIME_W-1:0];
      it.on = 1'($urandom_range(0, 1));
      it.heat = 1'($urandom_range(0, 1));
      it.temp = TEMP_W'($urandom_range(0, 127));
      return it;
   endfunction

   // write both registers back to back while the block is idle
   task automatic write_registers(input int lead, input int idle_wait);
      csr_valid <= 1'b1;
      csr_index <= CSR_LEAD;
      csr_wdata <= lead[TIME_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(CSR_LEAD, lead[TIME_W-1:0]);
      csr_index <= CSR_IDLE;
      csr_wdata <= idle_wait[TIME_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(CSR_IDLE, idle_wait[TIME_W-1:0]);
      csr_valid <= 1'b0;
   endtask

   // wait for every pending report, then let the block settle
   task automatic drain();
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: check taken items, then choose the next stall
   always @(posedge clock) begin
      sched_report_type got;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_fired, rsp_cmd_on, rsp_cmd_type, rsp_cmd_temp,
                   rsp_wait_seconds, rsp_status, rsp_entry_count};
            sb.check_report(got);
            results_taken = results_taken + 1;
            // long hold-offs so the block backs up into its input
            if (results_taken == 60 || results_taken == 500) hold_left = HOLD_CYCLES;
         end
         if (cycle_count % 97 == 0) stall_style = $urandom_range(0, 3);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else begin
            case (stall_style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= cycle_count[1];
            endcase
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles, %0d reports pending",
                  quiet_cycles, sb.pending());
         $display("[time_of_day_event_scheduler_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin
      int i;
      int phase;
      int n;
      int lead;
      int idle_wait;
      int clear_pct;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table cases at reset register values
      offer(MODE_TICK, 0, 0, 0, 0, 0);
      offer(MODE_REPORT, SECONDS_PER_DAY - 1, SECONDS_PER_DAY - 1, 1, 1, 127);
      offer(MODE_CLEAR, 100, 0, 0, 0, 0);
      // adds later, equal and earlier than now, at both ends of the day
      offer(MODE_ADD, 0, SECONDS_PER_DAY - 1, 1, 1, 127);
      offer(MODE_ADD, 50000, 50000, 0, 0, 0);
      offer(MODE_ADD, 50000, 60000, 1, 0, 64);
      offer(MODE_ADD, 50000, 10000, 0, 1, 1);
      offer(MODE_ADD, SECONDS_PER_DAY - 1, 0, 1, 0, 33);
      offer(MODE_ADD, 0, 0, 0, 1, 99);
      // fill the table
      for (i = 0; i < DEPTH - 6; i++)
         offer(MODE_ADD, 43200, i * 8000 + 123, i % 2, (i / 2) % 2, i * 13);
      // full table drops the add
      offer(MODE_ADD, 65536, 65535, 1, 1, 85);
      offer(MODE_REPORT, 65536, 0, 0, 0, 0);
      // ticks: due at end of day, borderline at midnight with the lead
      offer(MODE_TICK, SECONDS_PER_DAY - 1, 0, 0, 0, 0);
      offer(MODE_TICK, 0, 0, 0, 0, 0);
      offer(MODE_TICK, 0, 0, 0, 0, 0);
      offer(MODE_CLEAR, 0, 0, 0, 0, 0);
      offer(MODE_ADD, 1000, 900, 1, 1, 42);
      offer(MODE_TICK, 900, 0, 0, 0, 0);
      req_valid <= 1'b0;

      // random phases, each under its own register setting
      for (phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: begin lead = 0; idle_wait = 0; max_gap = 0; clear_pct = 2; end
            1: begin
               lead = 255; idle_wait = SECONDS_PER_DAY - 1; max_gap = 12; clear_pct = 8;
            end
            2: begin
               lead = $urandom_range(0, 255);
               idle_wait = $urandom_range(0, SECONDS_PER_DAY - 1);
               max_gap = 4;
               clear_pct = 1;
            end
            3: begin
               lead = 1; idle_wait = $urandom_range(0, SECONDS_PER_DAY - 1);
               max_gap = 20; clear_pct = 5;
            end
            default: begin
               lead = int'(LEAD_RESET); idle_wait = int'(IDLE_RESET);
               max_gap = 8; clear_pct = 3;
            end
         endcase
         write_registers(lead, idle_wait);
         @(posedge clock);
         for (n = 0; n < 150; n++) send_item(random_item(clear_pct));
         req_valid <= 1'b0;
      end

      drain();
      if (sb.pending() != 0) sb.report($sformatf("%0d reports never arrived", sb.pending()));
      $display("ran %0d items over 6 register settings, %0d results checked",
               items_sent, sb.checked);
      $display("%0d commands fired, %0d adds dropped on a full table, %0d mismatches",
               sb.fired_count, sb.drop_count, sb.errors);
      if (sb.errors == 0) begin
         $display("[time_of_day_event_scheduler_unit] OK");
      end else begin
         $display("[time_of_day_event_scheduler_unit] ERROR");
      end
      $finish;
   end

endmodule

/* time_of_day_event_scheduler_unit.f */
rtl/tdes_pkg.sv
rtl/tdes_ram.sv
rtl/time_of_day_event_scheduler_unit.sv
dv/tb_time_of_day_event_scheduler_unit.sv
